// File: rtl/cks_pkg.sv
// Shared constants, types and the cone profile function for the heat-map splat core.
// No dependencies; imported by every module of the block except cks_ram.
`default_nettype none

package cks_pkg;

   localparam int IMG_WIDTH  = 256;
   localparam int IMG_HEIGHT = 256;
   localparam int RADIUS     = 10;

   localparam int KSIDE  = 2 * RADIUS + 1;
   localparam int NPIX   = IMG_WIDTH * IMG_HEIGHT;
   localparam int ADDR_W = $clog2(NPIX);
   localparam int COL_W  = (IMG_WIDTH > 1) ? $clog2(IMG_WIDTH) : 1;
   localparam int ROW_W  = (IMG_HEIGHT > 1) ? $clog2(IMG_HEIGHT) : 1;
   localparam int KC_W   = $clog2(KSIDE);
   localparam int WGT_W  = $clog2(RADIUS + 1);
   localparam int DIM_W  = $clog2(((IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT) + 512);
   localparam int CNT_W  = 32;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X    = 3'd0,
      CSR_ORIGIN_Y    = 3'd1,
      CSR_SCALE_X     = 3'd2,
      CSR_SCALE_Y     = 3'd3,
      CSR_WIDTH_USED  = 3'd4,
      CSR_HEIGHT_USED = 3'd5
   } csr_idx_type;

   typedef enum logic {
      OP_SPLAT = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP_X,
      ST_MAP_Y,
      ST_MAP_FIN,
      ST_CELLS,
      ST_DRAIN,
      ST_RD_ISSUE,
      ST_RD_DATA
   } state_type;

   typedef struct packed {
      logic clr_en;
      logic capture;
      logic map_x;
      logic map_y;
      logic map_fin;
      logic cell_run;
      logic rd_issue;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic cell_last;
      logic out_free;
   } status_type;

   // weight = max(0, RADIUS - floor(sqrt(dx^2 + dy^2))) for kernel cell (kx, ky)
   function automatic logic [WGT_W-1:0] cone_weight(input logic [KC_W-1:0] kx,
                                                    input logic [KC_W-1:0] ky);
      int ax;
      int ay;
      int n;
      int s;
      ax = int'(kx) - RADIUS;
      ay = int'(ky) - RADIUS;
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      n = ax * ax + ay * ay;
      s = 0;
      for (int r = 1; r <= 2 * RADIUS; r++) begin
         if (r * r <= n) s = r;
      end
      if (s >= RADIUS) return '0;
      return WGT_W'(RADIUS - s);
   endfunction

endpackage

`default_nettype wire

// File: rtl/cks_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cks_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: rtl/cks_ctrl.sv
// Controller state machine for the heat-map splat core.
// Depends on cks_pkg; drives cmd_type commands into cks_dp and reads status_type back.
`default_nettype none

module cks_ctrl import cks_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_opcode,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (op_type'(req_opcode) == OP_READ) ? ST_RD_ISSUE : ST_MAP_X;
            end
         end
         ST_MAP_X:    state_in = ST_MAP_Y;
         ST_MAP_Y:    state_in = ST_MAP_FIN;
         ST_MAP_FIN:  state_in = ST_CELLS;
         ST_CELLS: begin
            if (status.cell_last) state_in = ST_DRAIN;
         end
         ST_DRAIN:    state_in = ST_IDLE;
         ST_RD_ISSUE: state_in = ST_RD_DATA;
         ST_RD_DATA: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR:    cmd.clr_en = 1'b1;
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_MAP_X:    cmd.map_x = 1'b1;
         ST_MAP_Y:    cmd.map_y = 1'b1;
         ST_MAP_FIN:  cmd.map_fin = 1'b1;
         ST_CELLS:    cmd.cell_run = 1'b1;
         ST_DRAIN:    ;
         ST_RD_ISSUE: cmd.rd_issue = 1'b1;
         ST_RD_DATA:  cmd.rsp_load = status.out_free;
         default:     ;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/cks_dp.sv
// Datapath: config registers, coordinate mapping, kernel sweep, read-modify-write, output reg.
// Depends on cks_pkg and cks_ram; steered by cmd_type from cks_ctrl.
`default_nettype none

module cks_dp import cks_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic signed [30:0]    req_point_lon,
   input  logic signed [29:0]    req_point_lat,
   input  logic [7:0]            req_read_col,
   input  logic [7:0]            req_read_row,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CNT_W-1:0]      rsp_pixel_count,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [30:0] origin_x_ff, origin_x_in;
   logic [29:0] origin_y_ff, origin_y_in;
   logic [31:0] scale_x_ff, scale_x_in;
   logic [31:0] scale_y_ff, scale_y_in;
   logic [8:0]  width_used_ff, width_used_in;
   logic [8:0]  height_used_ff, height_used_in;

   always_comb begin
      origin_x_in    = origin_x_ff;
      origin_y_in    = origin_y_ff;
      scale_x_in     = scale_x_ff;
      scale_y_in     = scale_y_ff;
      width_used_in  = width_used_ff;
      height_used_in = height_used_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_ORIGIN_X:    origin_x_in    = csr_wdata[30:0];
            CSR_ORIGIN_Y:    origin_y_in    = csr_wdata[29:0];
            CSR_SCALE_X:     scale_x_in     = csr_wdata;
            CSR_SCALE_Y:     scale_y_in     = csr_wdata;
            CSR_WIDTH_USED:  width_used_in  = csr_wdata[8:0];
            CSR_HEIGHT_USED: height_used_in = csr_wdata[8:0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         scale_x_ff     <= '0;
         scale_y_ff     <= '0;
         width_used_ff  <= 9'd256;
         height_used_ff <= 9'd256;
      end else begin
         origin_x_ff    <= origin_x_in;
         origin_y_ff    <= origin_y_in;
         scale_x_ff     <= scale_x_in;
         scale_y_ff     <= scale_y_in;
         width_used_ff  <= width_used_in;
         height_used_ff <= height_used_in;
      end
   end

   // transaction capture and coordinate mapping
   logic [31:0]       d_x_ff, d_x_in;
   logic [31:0]       d_y_ff, d_y_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic              rd_oob_ff, rd_oob_in;
   logic [62:0]       prod_ff, prod_in;
   logic              neg_ff, neg_in;
   logic [32:0]       ix0_ff, ix0_in;
   logic [32:0]       iy0_ff, iy0_in;
   logic [31:0]       mul_d;
   logic [31:0]       mul_abs;
   logic [31:0]       mul_b;
   logic              mul_neg;
   logic [63:0]       prod_rnd;
   logic [32:0]       fix_val;

   always_comb begin
      d_x_in     = d_x_ff;
      d_y_in     = d_y_ff;
      rd_addr_in = rd_addr_ff;
      rd_oob_in  = rd_oob_ff;
      if (cmd.capture) begin
         d_x_in = {req_point_lon[30], req_point_lon} - {origin_x_ff[30], origin_x_ff};
         d_y_in = {{2{req_point_lat[29]}}, req_point_lat} - {{2{origin_y_ff[29]}}, origin_y_ff};
         rd_addr_in = ADDR_W'(req_read_row) * ADDR_W'(IMG_WIDTH) + ADDR_W'(req_read_col);
         rd_oob_in  = (DIM_W'(req_read_col) >= DIM_W'(IMG_WIDTH)) ||
                      (DIM_W'(req_read_row) >= DIM_W'(IMG_HEIGHT));
      end
   end

   always_comb begin
      mul_d    = cmd.map_y ? d_y_ff : d_x_ff;
      mul_b    = cmd.map_y ? scale_y_ff : scale_x_ff;
      mul_neg  = mul_d[31];
      mul_abs  = mul_neg ? (32'd0 - mul_d) : mul_d;
      prod_in  = prod_ff;
      neg_in   = neg_ff;
      if (cmd.map_x || cmd.map_y) begin
         prod_in = 63'(mul_abs[30:0]) * 63'(mul_b);
         neg_in  = mul_neg;
      end
      // floor of a negative product: negate the ceiling of its magnitude
      prod_rnd = 64'(prod_ff) + 64'(32'hFFFF_FFFF);
      fix_val  = neg_ff ? (33'd0 - 33'(prod_rnd[63:32])) : 33'(prod_ff[62:32]);
      ix0_in   = cmd.map_y ? fix_val : ix0_ff;
      iy0_in   = cmd.map_fin ? fix_val : iy0_ff;
   end

   always_ff @(posedge clock) begin
      d_x_ff     <= d_x_in;
      d_y_ff     <= d_y_in;
      rd_addr_ff <= rd_addr_in;
      rd_oob_ff  <= rd_oob_in;
      prod_ff    <= prod_in;
      neg_ff     <= neg_in;
      ix0_ff     <= ix0_in;
      iy0_ff     <= iy0_in;
   end

   // kernel sweep
   logic [KC_W-1:0]   kx_ff, kx_in;
   logic [KC_W-1:0]   ky_ff, ky_in;
   logic [33:0]       cx;
   logic [33:0]       cy;
   logic [DIM_W-1:0]  wu;
   logic [DIM_W-1:0]  hu;
   logic              cell_inb;
   logic [ADDR_W-1:0] cell_addr;
   logic              k_row_end;

   always_comb begin
      k_row_end = (kx_ff == KC_W'(KSIDE - 1));
      kx_in     = kx_ff;
      ky_in     = ky_ff;
      if (cmd.map_fin) begin
         kx_in = '0;
         ky_in = '0;
      end else if (cmd.cell_run) begin
         kx_in = k_row_end ? '0 : kx_ff + KC_W'(1);
         ky_in = k_row_end ? ky_ff + KC_W'(1) : ky_ff;
      end
      wu = (DIM_W'(width_used_ff) > DIM_W'(IMG_WIDTH)) ? DIM_W'(IMG_WIDTH)
                                                      : DIM_W'(width_used_ff);
      hu = (DIM_W'(height_used_ff) > DIM_W'(IMG_HEIGHT)) ? DIM_W'(IMG_HEIGHT)
                                                        : DIM_W'(height_used_ff);
      cx = {ix0_ff[32], ix0_ff} + 34'(kx_ff) - 34'(RADIUS);
      cy = {iy0_ff[32], iy0_ff} + 34'(ky_ff) - 34'(RADIUS);
      cell_inb  = !cx[33] && (cx < 34'(wu)) && !cy[33] && (cy < 34'(hu));
      cell_addr = ADDR_W'(cy[ROW_W-1:0]) * ADDR_W'(IMG_WIDTH) + ADDR_W'(cx[COL_W-1:0]);
   end

   always_ff @(posedge clock) begin
      kx_ff <= kx_in;
      ky_ff <= ky_in;
   end

   // read-modify-write pipeline: read at cell k, write back in the following cycle
   logic              wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [WGT_W-1:0]  wr_wgt_ff, wr_wgt_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [CNT_W:0]    sum;
   logic [CNT_W-1:0]  sat;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [CNT_W-1:0]  ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [CNT_W-1:0]  ram_rdata;

   always_comb begin
      wr_pend_in = cmd.cell_run & cell_inb;
      wr_addr_in = cell_addr;
      wr_wgt_in  = cone_weight(kx_ff, ky_ff);
      clr_in     = cmd.clr_en ? clr_ff + ADDR_W'(1) : clr_ff;
      sum        = {1'b0, ram_rdata} + (CNT_W + 1)'(wr_wgt_ff);
      sat        = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
      ram_we     = cmd.clr_en | wr_pend_ff;
      ram_waddr  = cmd.clr_en ? clr_ff : wr_addr_ff;
      ram_wdata  = cmd.clr_en ? '0 : sat;
      ram_re     = cmd.rd_issue | (cmd.cell_run & cell_inb);
      ram_raddr  = cmd.rd_issue ? rd_addr_ff : cell_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pend_ff <= 1'b0;
         clr_ff     <= '0;
      end else begin
         wr_pend_ff <= wr_pend_in;
         clr_ff     <= clr_in;
      end
      wr_addr_ff <= wr_addr_in;
      wr_wgt_ff  <= wr_wgt_in;
   end

   cks_ram #(
      .WIDTH (CNT_W),
      .DEPTH (NPIX)
   ) u_image (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rd_oob_ff ? '0 : ram_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_count = rsp_data_ff;

   assign status.clr_last  = (clr_ff == ADDR_W'(NPIX - 1));
   assign status.cell_last = k_row_end && (ky_ff == KC_W'(KSIDE - 1));
   assign status.out_free  = ~rsp_valid_ff | rsp_ready;

endmodule

`default_nettype wire

// File: rtl/cone_kernel_heatmap_splat_core.sv
// Heat-map splat core top level: joins cks_ctrl and cks_dp.
// Depends on cks_pkg, cks_ctrl, cks_dp (and cks_ram inside cks_dp).
//
// Usage:
//   req channel (valid/ready) carries one transaction: opcode 0 splats a track point,
//   opcode 1 reads one pixel count. rsp channel returns one pixel_count per read;
//   a splat returns nothing. csr port writes a register on any cycle with csr_we high,
//   meant to be used only while the core is idle.
//   One transaction at a time. A splat keeps req_ready low after acceptance through
//   coordinate mapping (ST_MAP_X, ST_MAP_Y, ST_MAP_FIN) on the shared 31x32 multiplier,
//   one cycle per kernel cell (21 x 21 = 441, a pipelined read-modify-write on the
//   single image RAM port pair) and a drain state. A read passes an issue state and
//   a data state, then loads its result into the output register once that is free.
//   After reset the image RAM is cleared one entry per cycle: req_ready stays low until
//   every entry is cleared; csr writes are taken during that pass.
//   The output register holds a result while rsp_ready is low; a following splat is
//   still accepted and runs, a following read waits for the register to free up.
`default_nettype none

module cone_kernel_heatmap_splat_core import cks_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_opcode,
   input  logic signed [30:0]    req_point_lon,
   input  logic signed [29:0]    req_point_lat,
   input  logic [7:0]            req_read_col,
   input  logic [7:0]            req_read_row,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CNT_W-1:0]      rsp_pixel_count,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   cks_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   cks_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_point_lon   (req_point_lon),
      .req_point_lat   (req_point_lat),
      .req_read_col    (req_read_col),
      .req_read_row    (req_read_row),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_count (rsp_pixel_count),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

endmodule

`default_nettype wire

// File: rtl/cks_chk.sv
// Port-level checker for the heat-map splat core, bound to the top level.
// Depends on cks_pkg for widths.
`default_nettype none

module cks_chk import cks_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_opcode,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [CNT_W-1:0]      rsp_pixel_count
);

   // clearing pass blocks transactions right after reset
   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("req_ready high right after reset");

   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // one transaction at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready stayed high after a transaction");

   a_splat_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_opcode) |=> !$rose(rsp_valid))
      else $error("response raised right after a splat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pixel_count)))
      else $error("stalled response changed");

endmodule

bind cone_kernel_heatmap_splat_core cks_chk u_chk (.*);

`default_nettype wire
